### design/pcode_stack_machine_execute_assert.svh
// ----------------------------------------------------------------------------
// PL/0 p-code executor assertion macros
// Clocked, reset-qualified implication checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PCODE_STACK_MACHINE_EXECUTE_ASSERT_SVH
`define PCODE_STACK_MACHINE_EXECUTE_ASSERT_SVH

// same-cycle implication
`define PCODE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcode check failed");

// next-cycle implication
`define PCODE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcode check failed");

`endif

### design/pcode_pkg.sv
// ----------------------------------------------------------------------------
// PL/0 p-code executor package
// Opcodes, operation subcodes, stack reset values, sequencer states and address type.
// ----------------------------------------------------------------------------
package pcode_pkg;

  localparam logic [3:0] CMD_LIT  = 4'd0;
  localparam logic [3:0] CMD_OPR  = 4'd1;
  localparam logic [3:0] CMD_LOD  = 4'd2;
  localparam logic [3:0] CMD_STO  = 4'd3;
  localparam logic [3:0] CMD_CAL  = 4'd4;
  localparam logic [3:0] CMD_INT  = 4'd5;
  localparam logic [3:0] CMD_JMP  = 4'd6;
  localparam logic [3:0] CMD_JPC  = 4'd7;
  localparam logic [3:0] CMD_OUT  = 4'd8;
  localparam logic [3:0] CMD_LEA  = 4'd9;
  localparam logic [3:0] CMD_LODA = 4'd10;
  localparam logic [3:0] CMD_STOA = 4'd11;

  localparam logic signed [31:0] OPR_RET = 32'sd0;
  localparam logic signed [31:0] OPR_NEG = 32'sd1;
  localparam logic signed [31:0] OPR_ADD = 32'sd2;
  localparam logic signed [31:0] OPR_SUB = 32'sd3;
  localparam logic signed [31:0] OPR_MUL = 32'sd4;
  localparam logic signed [31:0] OPR_DIV = 32'sd5;
  localparam logic signed [31:0] OPR_ODD = 32'sd6;
  localparam logic signed [31:0] OPR_EQ  = 32'sd7;
  localparam logic signed [31:0] OPR_NE  = 32'sd8;
  localparam logic signed [31:0] OPR_LT  = 32'sd9;
  localparam logic signed [31:0] OPR_LE  = 32'sd10;
  localparam logic signed [31:0] OPR_GT  = 32'sd11;
  localparam logic signed [31:0] OPR_GE  = 32'sd12;

  localparam int TOP_RESET  = 3;
  localparam int BASE_RESET = 1;

  typedef logic signed [33:0] addr_t;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_CLEAR = 10'b00_0000_0010,
    S_WALK  = 10'b00_0000_0100,
    S_WALKW = 10'b00_0000_1000,
    S_RDA   = 10'b00_0001_0000,
    S_RDB   = 10'b00_0010_0000,
    S_EXEC  = 10'b00_0100_0000,
    S_DIV   = 10'b00_1000_0000,
    S_WR    = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

endpackage

### design/pcode_stack_machine_execute.sv
// ----------------------------------------------------------------------------
// PL/0 p-code stack machine execute unit
// Runs one p-code instruction per input item against an on-chip stack memory.
//
//   channel | handshake            | payload
//   in      | in_valid / in_ready  | cmd, level_diff, operand
//   out     | out_valid / out_ready| next_pc, halted, print_*, div_zero, stack_fault
//
// Steps: IDLE, WALK and WALKW per static-link step, RDA, RDB, EXEC, WR per
//   stack write (up to 3 for CAL), DONE; a divide waits in DIV on the bit-serial divider.
// Stack memory has one read and one write port and a registered read;
//   all reads of an item finish before its writes, so no forwarding is needed.
// Reset: a clearing pass zeroes the stack, with in_ready low.
// A finished result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
`include "pcode_stack_machine_execute_assert.svh"

module pcode_stack_machine_execute #(
  parameter int STACK_DEPTH = 1024,
  parameter int CODE_DEPTH  = 2048
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [3:0]                    cmd,
  input  logic [4:0]                    level_diff,
  input  logic signed [31:0]            operand,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [$clog2(CODE_DEPTH)-1:0] next_pc,
  output logic                          halted,
  output logic                          print_valid,
  output logic signed [31:0]            print_value,
  output logic                          print_newline,
  output logic                          div_zero,
  output logic                          stack_fault
);

  localparam int SW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(CODE_DEPTH);

  pcode_pkg::state_t state;

  logic [31:0] stack_mem [STACK_DEPTH];
  logic [31:0] rdata;
  logic        rd_oob;

  logic [3:0]         cmd_r;
  logic [4:0]         lvl;
  logic signed [31:0] opnd;
  logic [SW-1:0]      top;
  logic [SW-1:0]      base;
  logic [CW-1:0]      pc;
  logic [CW-1:0]      pc_seq;
  pcode_pkg::addr_t   wb;
  logic [31:0]        va;
  logic               fault;
  logic               dz;
  logic               pv;
  logic [31:0]        pval;
  logic               nl;
  pcode_pkg::addr_t   wr_addr;
  logic [31:0]        wr_data;
  logic [1:0]         wr_cnt;
  logic [SW-1:0]      clr_idx;
  logic [SW-1:0]      link_base;
  logic [CW-1:0]      link_pc;

  function automatic logic in_range(input pcode_pkg::addr_t a);
    return (a >= 34'sd0) && (a < 34'(STACK_DEPTH));
  endfunction

  pcode_pkg::addr_t tx, bx, opx;
  assign tx  = {{(34-SW){1'b0}}, top};
  assign bx  = {{(34-SW){1'b0}}, base};
  assign opx = {{2{opnd[31]}}, opnd};
  assign pc_seq = pc + 1'b1;

  logic is_opr, is_ret, is_neg, is_odd, is_arith, is_walk;
  assign is_opr   = cmd_r == pcode_pkg::CMD_OPR;
  assign is_ret   = is_opr && opnd == pcode_pkg::OPR_RET;
  assign is_neg   = is_opr && opnd == pcode_pkg::OPR_NEG;
  assign is_odd   = is_opr && opnd == pcode_pkg::OPR_ODD;
  assign is_arith = is_opr && opnd >= pcode_pkg::OPR_ADD && opnd <= pcode_pkg::OPR_GE && !is_odd;
  assign is_walk  = cmd == pcode_pkg::CMD_LOD || cmd == pcode_pkg::CMD_STO ||
                    cmd == pcode_pkg::CMD_CAL || cmd == pcode_pkg::CMD_LEA;

  logic [31:0]      rd_val;
  pcode_pkg::addr_t addr_a, addr_b;
  logic             need_a, need_b;
  assign rd_val = rd_oob ? 32'd0 : rdata;

  always_comb begin
    addr_a = tx;
    need_a = 1'b0;
    addr_b = tx;
    need_b = 1'b0;
    if (is_ret) begin
      addr_a = bx + 34'sd2;
      addr_b = bx + 34'sd1;
      need_a = 1'b1;
      need_b = 1'b1;
    end else if (is_neg || is_odd) begin
      need_a = 1'b1;
    end else if (is_arith) begin
      addr_a = tx - 34'sd1;
      need_a = 1'b1;
      need_b = 1'b1;
    end else begin
      case (cmd_r)
        pcode_pkg::CMD_LOD: begin
          addr_a = wb + opx;
          need_a = 1'b1;
        end
        pcode_pkg::CMD_STO, pcode_pkg::CMD_JPC: need_a = 1'b1;
        pcode_pkg::CMD_OUT: need_a = opnd == 32'sd0;
        pcode_pkg::CMD_LODA: begin
          need_a = 1'b1;
          addr_b = {{2{rd_val[31]}}, rd_val};
          need_b = 1'b1;
        end
        pcode_pkg::CMD_STOA: begin
          addr_a = tx - 34'sd1;
          need_a = 1'b1;
          need_b = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // execute stage: va holds the first read, rd_val the second
  logic [31:0]      y;
  logic [31:0]      mul_lo;
  pcode_pkg::addr_t t_new, b_new;
  logic             t_chg, b_chg;
  logic [CW-1:0]    pc_new;
  pcode_pkg::addr_t ex_waddr;
  logic [31:0]      ex_wdata;
  logic [1:0]       ex_wcnt;
  logic             ex_div, ex_dz, ex_pv, ex_nl;
  logic signed [31:0] xs, ys;

  assign y      = rd_val;
  assign xs     = va;
  assign ys     = y;
  assign mul_lo = va * y;

  always_comb begin
    t_new    = tx;
    t_chg    = 1'b0;
    b_new    = bx;
    b_chg    = 1'b0;
    pc_new   = pc_seq;
    ex_waddr = tx;
    ex_wdata = '0;
    ex_wcnt  = '0;
    ex_div   = 1'b0;
    ex_dz    = 1'b0;
    ex_pv    = 1'b0;
    ex_nl    = 1'b0;
    if (is_ret) begin
      t_new  = bx - 34'sd1;
      t_chg  = 1'b1;
      pc_new = va[CW-1:0];
      b_new  = {{2{y[31]}}, y};
      b_chg  = 1'b1;
    end else if (is_neg) begin
      ex_wdata = 32'd0 - va;
      ex_wcnt  = 2'd1;
    end else if (is_odd) begin
      ex_wdata = {31'd0, va[0]};
      ex_wcnt  = 2'd1;
    end else if (is_arith) begin
      ex_waddr = tx - 34'sd1;
      ex_wcnt  = 2'd1;
      t_new    = tx - 34'sd1;
      t_chg    = 1'b1;
      case (opnd)
        pcode_pkg::OPR_ADD: ex_wdata = va + y;
        pcode_pkg::OPR_SUB: ex_wdata = va - y;
        pcode_pkg::OPR_MUL: ex_wdata = mul_lo;
        pcode_pkg::OPR_DIV: begin
          if (y == 32'd0) begin
            ex_dz   = 1'b1;
            ex_wcnt = 2'd0;
          end else begin
            ex_div = 1'b1;
          end
        end
        pcode_pkg::OPR_EQ: ex_wdata = {31'd0, xs == ys};
        pcode_pkg::OPR_NE: ex_wdata = {31'd0, xs != ys};
        pcode_pkg::OPR_LT: ex_wdata = {31'd0, xs < ys};
        pcode_pkg::OPR_LE: ex_wdata = {31'd0, xs <= ys};
        pcode_pkg::OPR_GT: ex_wdata = {31'd0, xs > ys};
        default:           ex_wdata = {31'd0, xs >= ys};
      endcase
    end else begin
      case (cmd_r)
        pcode_pkg::CMD_LIT: begin
          ex_waddr = tx + 34'sd1;
          ex_wdata = opnd;
          ex_wcnt  = 2'd1;
          t_new    = tx + 34'sd1;
          t_chg    = 1'b1;
        end
        pcode_pkg::CMD_LOD: begin
          ex_waddr = tx + 34'sd1;
          ex_wdata = va;
          ex_wcnt  = 2'd1;
          t_new    = tx + 34'sd1;
          t_chg    = 1'b1;
        end
        pcode_pkg::CMD_STO: begin
          ex_waddr = wb + opx;
          ex_wdata = va;
          ex_wcnt  = 2'd1;
          t_new    = tx - 34'sd1;
          t_chg    = 1'b1;
        end
        pcode_pkg::CMD_CAL: begin
          ex_waddr = tx + 34'sd1;
          ex_wcnt  = 2'd3;
          b_new    = tx + 34'sd1;
          b_chg    = 1'b1;
          pc_new   = opnd[CW-1:0];
        end
        pcode_pkg::CMD_INT: begin
          t_new = tx + opx;
          t_chg = 1'b1;
        end
        pcode_pkg::CMD_JMP: pc_new = opnd[CW-1:0];
        pcode_pkg::CMD_JPC: begin
          if (va == 32'd0) pc_new = opnd[CW-1:0];
          t_new = tx - 34'sd1;
          t_chg = 1'b1;
        end
        pcode_pkg::CMD_OUT: begin
          if (opnd == 32'sd0) begin
            ex_pv = 1'b1;
            t_new = tx - 34'sd1;
            t_chg = 1'b1;
          end else begin
            ex_nl = 1'b1;
          end
        end
        pcode_pkg::CMD_LEA: begin
          pcode_pkg::addr_t ea;
          ea       = wb + opx;
          ex_waddr = tx + 34'sd1;
          ex_wdata = ea[31:0];
          ex_wcnt  = 2'd1;
          t_new    = tx + 34'sd1;
          t_chg    = 1'b1;
        end
        pcode_pkg::CMD_LODA: begin
          ex_wdata = y;
          ex_wcnt  = 2'd1;
        end
        pcode_pkg::CMD_STOA: begin
          ex_waddr = {{2{va[31]}}, va};
          ex_wdata = y;
          ex_wcnt  = 2'd1;
          t_new    = tx - 34'sd2;
          t_chg    = 1'b1;
        end
        default: ;
      endcase
    end
  end

  logic        div_done;
  logic [31:0] div_quo;
  logic        div_start;
  assign div_start = state == pcode_pkg::S_EXEC && ex_div;

  pcode_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (va),
    .divisor  (y),
    .done     (div_done),
    .quotient (div_quo)
  );

  // read port address
  pcode_pkg::addr_t rd_a;
  always_comb begin
    unique case (state)
      pcode_pkg::S_WALK: rd_a = wb;
      pcode_pkg::S_RDB:  rd_a = addr_b;
      default:           rd_a = addr_a;
    endcase
  end

  // write port
  logic          mem_we;
  logic [SW-1:0] mem_widx;
  logic [31:0]   mem_wdata;
  logic [31:0]   wr_word;
  logic          is_cal;
  assign is_cal = cmd_r == pcode_pkg::CMD_CAL;

  always_comb begin
    if (is_cal) begin
      case (wr_cnt)
        2'd3:    wr_word = wb[31:0];
        2'd2:    wr_word = {{(32-SW){1'b0}}, link_base};
        default: wr_word = {{(32-CW){1'b0}}, link_pc};
      endcase
    end else begin
      wr_word = wr_data;
    end
  end

  always_comb begin
    if (state == pcode_pkg::S_CLEAR) begin
      mem_we    = 1'b1;
      mem_widx  = clr_idx;
      mem_wdata = '0;
    end else begin
      mem_we    = state == pcode_pkg::S_WR && in_range(wr_addr);
      mem_widx  = wr_addr[SW-1:0];
      mem_wdata = wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) stack_mem[mem_widx] <= mem_wdata;
    rdata <= stack_mem[rd_a[SW-1:0]];
  end

  assign in_ready = state == pcode_pkg::S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pcode_pkg::S_CLEAR;
      clr_idx   <= '0;
      top       <= SW'(pcode_pkg::TOP_RESET);
      base      <= SW'(pcode_pkg::BASE_RESET);
      pc        <= '0;
      out_valid <= 1'b0;
      wr_cnt    <= '0;
      rd_oob    <= 1'b0;
      fault     <= 1'b0;
    end else begin
      rd_oob <= !in_range(rd_a);
      if (state == pcode_pkg::S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        pcode_pkg::S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == SW'(STACK_DEPTH - 1)) state <= pcode_pkg::S_IDLE;
        end
        pcode_pkg::S_IDLE: begin
          if (in_valid) begin
            cmd_r <= cmd;
            lvl   <= level_diff;
            opnd  <= operand;
            wb    <= bx;
            fault <= 1'b0;
            state <= (is_walk && level_diff != 5'd0) ? pcode_pkg::S_WALK
                                                     : pcode_pkg::S_RDA;
          end
        end
        pcode_pkg::S_WALK: begin
          if (!in_range(wb)) fault <= 1'b1;
          state <= pcode_pkg::S_WALKW;
        end
        pcode_pkg::S_WALKW: begin
          wb  <= {{2{rd_val[31]}}, rd_val};
          lvl <= lvl - 5'd1;
          state <= (lvl == 5'd1) ? pcode_pkg::S_RDA : pcode_pkg::S_WALK;
        end
        pcode_pkg::S_RDA: begin
          if (need_a && !in_range(addr_a)) fault <= 1'b1;
          state <= pcode_pkg::S_RDB;
        end
        pcode_pkg::S_RDB: begin
          va <= rd_val;
          if (need_b && !in_range(addr_b)) fault <= 1'b1;
          state <= pcode_pkg::S_EXEC;
        end
        pcode_pkg::S_EXEC: begin
          if ((t_chg && !in_range(t_new)) || (b_chg && !in_range(b_new))) fault <= 1'b1;
          if (t_chg) top <= t_new[SW-1:0];
          if (b_chg) base <= b_new[SW-1:0];
          link_base <= base;
          link_pc   <= pc_seq;
          pc      <= pc_new;
          wr_addr <= ex_waddr;
          wr_data <= ex_wdata;
          wr_cnt  <= ex_wcnt;
          dz      <= ex_dz;
          pv      <= ex_pv;
          pval    <= ex_pv ? va : 32'd0;
          nl      <= ex_nl;
          if (ex_div) state <= pcode_pkg::S_DIV;
          else if (ex_wcnt != 2'd0) state <= pcode_pkg::S_WR;
          else state <= pcode_pkg::S_DONE;
        end
        pcode_pkg::S_DIV: begin
          if (div_done) begin
            wr_data <= div_quo;
            state   <= pcode_pkg::S_WR;
          end
        end
        pcode_pkg::S_WR: begin
          if (!in_range(wr_addr)) fault <= 1'b1;
          wr_addr <= wr_addr + 34'sd1;
          wr_cnt  <= wr_cnt - 2'd1;
          if (wr_cnt == 2'd1) state <= pcode_pkg::S_DONE;
        end
        pcode_pkg::S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= pcode_pkg::S_IDLE;
          end
        end
        default: state <= pcode_pkg::S_IDLE;
      endcase
    end
  end

  // hold result payload while the item waits
  always_ff @(posedge clk) begin
    if (state == pcode_pkg::S_DONE && (!out_valid || out_ready)) begin
      next_pc       <= pc;
      halted        <= pc == '0;
      print_valid   <= pv;
      print_value   <= pval;
      print_newline <= nl;
      div_zero      <= dz;
      stack_fault   <= fault;
    end
  end

  `PCODE_ASSERT_NOW(a_no_accept_in_clear, state == pcode_pkg::S_CLEAR, !in_ready)
  `PCODE_ASSERT_NOW(a_halt_matches_pc, out_valid, halted == (next_pc == '0))
  `PCODE_ASSERT_NOW(a_dz_no_print, out_valid && div_zero, !print_valid && !print_newline)
  `PCODE_ASSERT_NEXT(a_wr_then_count, state == pcode_pkg::S_WR && wr_cnt != 2'd1,
                     state == pcode_pkg::S_WR)

endmodule

### design/pcode_div.sv
// ----------------------------------------------------------------------------
// PL/0 p-code signed divider
// Restoring divide, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module pcode_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] dividend,
  input  logic signed [31:0] divisor,
  output logic               done,
  output logic        [31:0] quotient
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dmag;
  logic        neg;
  logic [32:0] rem_sh;
  logic        ge;

  assign rem_sh   = {rem, quo[31]};
  assign ge       = rem_sh >= {1'b0, dmag};
  assign quotient = neg ? 32'd0 - quo : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend[31] ? 32'd0 - dividend : dividend;
      dmag <= divisor[31] ? 32'd0 - divisor : divisor;
      neg  <= dividend[31] ^ divisor[31];
      rem  <= '0;
    end else if (busy) begin
      rem <= ge ? 32'(rem_sh - {1'b0, dmag}) : rem_sh[31:0];
      quo <= {quo[30:0], ge};
    end
  end

endmodule

### tb/sv/pcode_exec_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// P-code executor result checker
// Watches both channels, runs each accepted instruction through its own copy
// of the stack machine and compares every result field with the prediction.
// ----------------------------------------------------------------------------
module pcode_exec_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [3:0]         cmd,
  input  logic [4:0]         level_diff,
  input  logic signed [31:0] operand,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [10:0]        next_pc,
  input  logic               halted,
  input  logic               print_valid,
  input  logic signed [31:0] print_value,
  input  logic               print_newline,
  input  logic               div_zero,
  input  logic               stack_fault,
  output int                 fail_count,
  output int                 pending,
  output int                 checked
);

  localparam int STACK_WORDS = 1024;
  localparam int CODE_WORDS  = 2048;

  typedef struct packed {
    logic [10:0] npc;
    logic        halt;
    logic        pv;
    logic [31:0] pval;
    logic        nl;
    logic        dz;
    logic        sf;
  } step_result_t;

  step_result_t expected_steps[$];

  logic [31:0] stack_words [STACK_WORDS];
  int          top_idx;
  int          base_idx;
  int          pc_reg;
  logic        fault;

  function automatic longint sx(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic logic [31:0] rd(longint idx);
    if (idx < 0 || idx >= STACK_WORDS) begin
      fault = 1'b1;
      return 32'd0;
    end
    return stack_words[idx];
  endfunction

  function automatic void wr(longint idx, logic [31:0] v);
    if (idx < 0 || idx >= STACK_WORDS) begin
      fault = 1'b1;
      return;
    end
    stack_words[idx] = v;
  endfunction

  function automatic int fold_stack(longint v);
    if (v < 0 || v >= STACK_WORDS) fault = 1'b1;
    return int'(((v % STACK_WORDS) + STACK_WORDS) % STACK_WORDS);
  endfunction

  function automatic int fold_code(longint v);
    return int'(((v % CODE_WORDS) + CODE_WORDS) % CODE_WORDS);
  endfunction

  function automatic longint follow_links(logic [4:0] steps);
    longint b;
    b = base_idx;
    for (int i = 0; i < steps; i++) b = sx(rd(b));
    return b;
  endfunction

  function automatic step_result_t execute_instr(logic [3:0] c, logic [4:0] l,
                                                 logic signed [31:0] op);
    step_result_t r;
    longint t, b, x, y, q, opl;
    logic [31:0] v, rp, rb, res;
    logic keep;
    t = top_idx;
    b = base_idx;
    opl = longint'(op);
    r = '0;
    fault = 1'b0;
    pc_reg = fold_code(longint'(pc_reg) + 1);
    case (c)
      pcode_pkg::CMD_LIT: begin
        wr(t + 1, op);
        top_idx = fold_stack(t + 1);
      end
      pcode_pkg::CMD_OPR: begin
        if (op == pcode_pkg::OPR_RET) begin
          rp = rd(b + 2);
          rb = rd(b + 1);
          top_idx = fold_stack(b - 1);
          pc_reg = fold_code(sx(rp));
          base_idx = fold_stack(sx(rb));
        end else if (op == pcode_pkg::OPR_NEG) begin
          wr(t, 32'd0 - rd(t));
        end else if (op == pcode_pkg::OPR_ODD) begin
          wr(t, rd(t) & 32'd1);
        end else if (op >= pcode_pkg::OPR_ADD && op <= pcode_pkg::OPR_GE) begin
          x = sx(rd(t - 1));
          y = sx(rd(t));
          keep = 1'b1;
          res = '0;
          case (op)
            pcode_pkg::OPR_ADD: res = x[31:0] + y[31:0];
            pcode_pkg::OPR_SUB: res = x[31:0] - y[31:0];
            pcode_pkg::OPR_MUL: res = x[31:0] * y[31:0];
            pcode_pkg::OPR_DIV: begin
              if (y == 0) begin
                r.dz = 1'b1;
                keep = 1'b0;
              end else begin
                q = x / y;
                res = q[31:0];
              end
            end
            pcode_pkg::OPR_EQ: res = 32'(x == y);
            pcode_pkg::OPR_NE: res = 32'(x != y);
            pcode_pkg::OPR_LT: res = 32'(x < y);
            pcode_pkg::OPR_LE: res = 32'(x <= y);
            pcode_pkg::OPR_GT: res = 32'(x > y);
            default: res = 32'(x >= y);
          endcase
          if (keep) wr(t - 1, res);
          top_idx = fold_stack(t - 1);
        end
      end
      pcode_pkg::CMD_LOD: begin
        v = rd(follow_links(l) + opl);
        wr(t + 1, v);
        top_idx = fold_stack(t + 1);
      end
      pcode_pkg::CMD_STO: begin
        x = follow_links(l) + opl;
        wr(x, rd(t));
        top_idx = fold_stack(t - 1);
      end
      pcode_pkg::CMD_CAL: begin
        x = follow_links(l);
        wr(t + 1, x[31:0]);
        wr(t + 2, b[31:0]);
        wr(t + 3, pc_reg[31:0]);
        base_idx = fold_stack(t + 1);
        pc_reg = fold_code(opl);
      end
      pcode_pkg::CMD_INT: top_idx = fold_stack(t + opl);
      pcode_pkg::CMD_JMP: pc_reg = fold_code(opl);
      pcode_pkg::CMD_JPC: begin
        if (rd(t) == 32'd0) pc_reg = fold_code(opl);
        top_idx = fold_stack(t - 1);
      end
      pcode_pkg::CMD_OUT: begin
        if (op == 0) begin
          r.pval = rd(t);
          r.pv = 1'b1;
          top_idx = fold_stack(t - 1);
        end else begin
          r.nl = 1'b1;
        end
      end
      pcode_pkg::CMD_LEA: begin
        x = follow_links(l) + opl;
        wr(t + 1, x[31:0]);
        top_idx = fold_stack(t + 1);
      end
      pcode_pkg::CMD_LODA: begin
        v = rd(t);
        wr(t, rd(sx(v)));
      end
      pcode_pkg::CMD_STOA: begin
        v = rd(t - 1);
        wr(sx(v), rd(t));
        top_idx = fold_stack(t - 2);
      end
      default: ;
    endcase
    r.npc = pc_reg[10:0];
    r.halt = (pc_reg[10:0] == 11'd0);
    r.sf = fault;
    return r;
  endfunction

  always @(posedge clk) begin
    step_result_t got, want;
    if (rst) begin
      for (int i = 0; i < STACK_WORDS; i++) stack_words[i] = '0;
      top_idx = pcode_pkg::TOP_RESET;
      base_idx = pcode_pkg::BASE_RESET;
      pc_reg = 0;
      expected_steps.delete();
      fail_count <= 0;
      checked <= 0;
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {next_pc, halted, print_valid, print_value, print_newline, div_zero,
               stack_fault};
        checked <= checked + 1;
        if (expected_steps.size() == 0) begin
          if (fail_count < 10) $display("result with no instruction pending: %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_steps.pop_front();
          if (got !== want) begin
            if (fail_count < 10) $display("result %0d: expected %p got %p", checked, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready)
        expected_steps.push_back(execute_instr(cmd, level_diff, operand));
      pending <= expected_steps.size();
    end
  end

endmodule

### tb/sv/tb_pcode_stack_machine_execute.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// P-code stack machine execute testbench
// Feeds directed and random p-code sequences (calls, returns, arithmetic,
// indirect access, jumps, console output and noise) under random idling on
// both channels; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_pcode_stack_machine_execute;

  localparam int ITEM_TARGET = 1100;
  localparam int IDLE_LIMIT  = 6000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [3:0]         cmd = '0;
  logic [4:0]         level_diff = '0;
  logic signed [31:0] operand = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [10:0]        next_pc;
  logic               halted;
  logic               print_valid;
  logic signed [31:0] print_value;
  logic               print_newline;
  logic               div_zero;
  logic               stack_fault;
  int                 fail_count;
  int                 pending;
  int                 checked;
  int                 sent = 0;
  int                 idle_cycles = 0;
  int                 stall_left = 0;
  logic               no_idle = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pcode_stack_machine_execute i_dut (.*);

  pcode_exec_checker i_checker (.*);

  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst || no_idle) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      stall_left <= gap_len();
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", IDLE_LIMIT);
      $display("pcode_stack_machine_execute: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic issue(logic [3:0] c, logic [4:0] l, logic signed [31:0] op);
    int g;
    logic ok;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    level_diff <= l;
    operand <= op;
    do begin
      @(negedge clk);
      ok = in_ready;
      @(posedge clk);
    end while (!ok);
    sent++;
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return -$signed({1'b0, 31'($urandom_range(0, 20))});
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  task automatic random_block();
    int k;
    k = $urandom_range(0, 99);
    if (k < 18) issue(pcode_pkg::CMD_LIT, 5'($urandom), rand_value());
    else if (k < 35) begin
      issue(pcode_pkg::CMD_LIT, 0, rand_value());
      issue(pcode_pkg::CMD_OPR, 0, $urandom_range(pcode_pkg::OPR_ADD, pcode_pkg::OPR_GE));
    end else if (k < 40) begin
      issue(pcode_pkg::CMD_OPR, 0,
            $urandom_range(0, 1) ? pcode_pkg::OPR_NEG : pcode_pkg::OPR_ODD);
    end else if (k < 47) begin
      issue(pcode_pkg::CMD_LOD, 5'($urandom_range(0, 2)), $urandom_range(0, 8));
    end else if (k < 54) begin
      issue(pcode_pkg::CMD_STO, 5'($urandom_range(0, 2)), $urandom_range(3, 8));
    end else if (k < 62) begin
      issue(pcode_pkg::CMD_CAL, 5'($urandom_range(0, 1)), $urandom_range(1, 2047));
      issue(pcode_pkg::CMD_INT, 0, $urandom_range(3, 6));
      repeat ($urandom_range(0, 4)) issue(pcode_pkg::CMD_LIT, 0, rand_value());
      issue(pcode_pkg::CMD_OPR, 0, pcode_pkg::OPR_RET);
    end else if (k < 66) issue(pcode_pkg::CMD_JMP, 5'($urandom), rand_value());
    else if (k < 71) issue(pcode_pkg::CMD_JPC, 5'($urandom), $urandom_range(0, 2047));
    else if (k < 76) begin
      issue(pcode_pkg::CMD_OUT, 5'($urandom), $urandom_range(0, 1) ? 0 : $urandom);
    end else if (k < 82) begin
      issue(pcode_pkg::CMD_LEA, 5'($urandom_range(0, 1)), $urandom_range(0, 8));
      issue(pcode_pkg::CMD_LODA, 5'($urandom), $urandom);
    end else if (k < 88) begin
      issue(pcode_pkg::CMD_LEA, 5'($urandom_range(0, 1)), $urandom_range(0, 8));
      issue(pcode_pkg::CMD_LIT, 0, rand_value());
      issue(pcode_pkg::CMD_STOA, 5'($urandom), $urandom);
    end else if (k < 91) begin
      issue(pcode_pkg::CMD_INT, 0, $signed(32'($urandom_range(0, 8))) - 4);
    end else issue(4'($urandom), 5'($urandom), $urandom);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, divide corner cases, calls, jumps, unknown codes
    issue(pcode_pkg::CMD_LIT, 0, 32'sh7fffffff);
    issue(pcode_pkg::CMD_LIT, 0, 32'sh80000000);
    issue(pcode_pkg::CMD_LIT, 0, -1);
    issue(pcode_pkg::CMD_OPR, 0, pcode_pkg::OPR_DIV);
    issue(pcode_pkg::CMD_LIT, 0, 0);
    issue(pcode_pkg::CMD_OPR, 0, pcode_pkg::OPR_DIV);
    issue(pcode_pkg::CMD_OPR, 0, pcode_pkg::OPR_NEG);
    issue(pcode_pkg::CMD_OPR, 0, pcode_pkg::OPR_ODD);
    issue(pcode_pkg::CMD_OPR, 0, pcode_pkg::OPR_MUL);
    issue(pcode_pkg::CMD_OPR, 0, 13);
    issue(pcode_pkg::CMD_OPR, 0, -1);
    issue(pcode_pkg::CMD_LOD, 31, 32'sh7fffffff);
    issue(pcode_pkg::CMD_STO, 0, -5);
    issue(pcode_pkg::CMD_CAL, 31, -3);
    issue(pcode_pkg::CMD_INT, 0, 5);
    issue(pcode_pkg::CMD_OUT, 0, 1);
    issue(pcode_pkg::CMD_OUT, 0, 0);
    issue(pcode_pkg::CMD_OPR, 0, pcode_pkg::OPR_RET);
    issue(pcode_pkg::CMD_JMP, 0, 0);
    issue(pcode_pkg::CMD_JPC, 0, 32'sh80000000);
    issue(pcode_pkg::CMD_LEA, 1, 2);
    issue(pcode_pkg::CMD_LODA, 0, 0);
    issue(pcode_pkg::CMD_STOA, 0, 0);
    issue(4'd15, 5'd31, -1);
    issue(pcode_pkg::CMD_INT, 0, 2000);

    while (sent < ITEM_TARGET) begin
      if (sent > 500 && sent < 520) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      no_idle <= (sent > 700 && sent < 800);
      random_block();
    end
    in_valid <= 1'b0;
    no_idle <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    $display("ran %0d instructions, %0d results checked", sent, checked);
    if (fail_count == 0 && pending == 0)
      $display("pcode_stack_machine_execute: match");
    else
      $display("pcode_stack_machine_execute: mismatch");
    $finish;
  end

endmodule
